[rtl/mctb_pkg.sv]
// ----------------------------------------------------------------------------
// mctb_pkg
// Shared widths and the command and status bundles between the controller
// and the datapath of the min Cartesian tree builder.
// ----------------------------------------------------------------------------
package mctb_pkg;

    localparam int KEY_W     = 32;
    localparam int OUT_IDX_W = 7;

    localparam logic ACT_PUSH   = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    typedef struct packed {
        logic load_key;
        logic set_ovf;
        logic rd_build;
        logic pop;
        logic link_parent;
        logic link_new;
        logic start_walk;
        logic rd_links;
        logic emit;
        logic emit_empty;
        logic step;
        logic take_pop;
        logic clear;
    } dp_cmd_t;

    typedef struct packed {
        logic depth_zero;
        logic depth_one;
        logic full;
        logic count_zero;
        logic pop_key;
        logic links_zero;
        logic sp_zero;
        logic out_free;
    } dp_status_t;

endpackage

[rtl/mctb_ctrl.sv]
// ----------------------------------------------------------------------------
// mctb_ctrl
// Sequencer for push (stack pops and linking) and finish (preorder walk).
// ----------------------------------------------------------------------------
module mctb_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   action,
    input  mctb_pkg::dp_status_t   status,
    output logic                   in_stall,
    output mctb_pkg::dp_cmd_t      cmd
);
    import mctb_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_LINK  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_WRD   = 3'd5;
    localparam logic [2:0] S_WEMIT = 3'd6;
    localparam logic [2:0] S_WPOP  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (action == ACT_PUSH)
                    begin
                        if (status.full)
                        begin
                            cmd.set_ovf = 1'b1;
                        end
                        else
                        begin
                            cmd.load_key = 1'b1;
                            state_next   = status.depth_zero ? S_LINK : S_RD;
                        end
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_RD:
            begin
                cmd.rd_build = 1'b1;
                state_next   = S_CMP;
            end
            S_CMP:
            begin
                if (status.pop_key)
                begin
                    cmd.pop    = 1'b1;
                    state_next = status.depth_one ? S_LINK : S_RD;
                end
                else
                begin
                    cmd.link_parent = 1'b1;
                    state_next      = S_LINK;
                end
            end
            S_LINK:
            begin
                cmd.link_new = 1'b1;
                state_next   = S_IDLE;
            end
            S_FIN:
            begin
                if (!status.count_zero)
                begin
                    cmd.start_walk = 1'b1;
                    state_next     = S_WRD;
                end
                else if (status.out_free)
                begin
                    cmd.emit_empty = 1'b1;
                    cmd.clear      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_WRD:
            begin
                cmd.rd_links = 1'b1;
                state_next   = S_WEMIT;
            end
            S_WEMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.links_zero && status.sp_zero)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.step   = 1'b1;
                        state_next = status.links_zero ? S_WPOP : S_WRD;
                    end
                end
            end
            S_WPOP:
            begin
                cmd.take_pop = 1'b1;
                state_next   = S_WRD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/mctb_dp.sv]
// ----------------------------------------------------------------------------
// mctb_dp
// Build stack, link memories, walk stack, counters and the result register.
// ----------------------------------------------------------------------------
module mctb_dp #(
    parameter int MAX_NODES = 64,
    parameter int KEY_BITS  = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [mctb_pkg::KEY_W-1:0]        key,
    input  mctb_pkg::dp_cmd_t                 cmd,
    output mctb_pkg::dp_status_t              status,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [mctb_pkg::OUT_IDX_W-1:0]    node_index,
    output logic [mctb_pkg::OUT_IDX_W-1:0]    left_child,
    output logic [mctb_pkg::OUT_IDX_W-1:0]    right_child,
    output logic                              is_last,
    output logic                              overflowed,
    output logic                              empty_tree
);
    import mctb_pkg::*;

    localparam int IDX_W  = $clog2(MAX_NODES + 1);
    localparam int ADDR_W = $clog2(MAX_NODES);
    localparam int CMP_W  = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

    function automatic logic [ADDR_W-1:0] node_addr(input logic [IDX_W-1:0] i);
        return ADDR_W'(i - IDX_W'(1));
    endfunction

    logic [IDX_W-1:0]  bidx_mem  [MAX_NODES];
    logic [CMP_W-1:0]  bkey_mem  [MAX_NODES];
    logic [IDX_W-1:0]  left_mem  [MAX_NODES];
    logic [IDX_W-1:0]  right_mem [MAX_NODES];
    logic [IDX_W-1:0]  wstk_mem  [MAX_NODES];

    logic [IDX_W-1:0]  depth_reg, depth_next;
    logic [IDX_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  root_reg,  root_next;
    logic [IDX_W-1:0]  sp_reg,    sp_next;
    logic [IDX_W-1:0]  cur_reg,   cur_next;
    logic [IDX_W-1:0]  last_reg,  last_next;
    logic              ovf_reg,   ovf_next;
    logic              oval_reg,  oval_next;

    logic [CMP_W-1:0]  nk_reg;
    logic [IDX_W-1:0]  bidx_rd_reg;
    logic [CMP_W-1:0]  bkey_rd_reg;
    logic [IDX_W-1:0]  l_rd_reg;
    logic [IDX_W-1:0]  r_rd_reg;
    logic [IDX_W-1:0]  w_rd_reg;

    logic [OUT_IDX_W-1:0] node_reg, left_reg, right_reg;
    logic                 last_out_reg, ovf_out_reg, empty_reg;

    logic [IDX_W-1:0]  new_idx;
    logic              rwr_en;
    logic [ADDR_W-1:0] rwr_addr;
    logic [IDX_W-1:0]  rwr_data;
    logic              l_nz, r_nz;

    assign new_idx  = count_reg + IDX_W'(1);
    assign l_nz     = (l_rd_reg != '0);
    assign r_nz     = (r_rd_reg != '0);
    assign rwr_en   = cmd.link_parent | cmd.link_new;
    assign rwr_addr = cmd.link_parent ? node_addr(bidx_rd_reg) : node_addr(new_idx);
    assign rwr_data = cmd.link_parent ? new_idx : '0;

    assign status.depth_zero = (depth_reg == '0);
    assign status.depth_one  = (depth_reg == IDX_W'(1));
    assign status.full       = (count_reg == IDX_W'(MAX_NODES));
    assign status.count_zero = (count_reg == '0);
    assign status.pop_key    = (bkey_rd_reg > nk_reg);
    assign status.links_zero = !l_nz && !r_nz;
    assign status.sp_zero    = (sp_reg == '0);
    assign status.out_free   = !oval_reg || !out_stall;

    always_comb
    begin
        depth_next = depth_reg;
        count_next = count_reg;
        root_next  = root_reg;
        sp_next    = sp_reg;
        cur_next   = cur_reg;
        last_next  = last_reg;
        ovf_next   = ovf_reg;
        oval_next  = oval_reg;

        if (cmd.load_key)
        begin
            last_next = '0;
        end
        if (cmd.set_ovf)
        begin
            ovf_next = 1'b1;
        end
        if (cmd.pop)
        begin
            depth_next = depth_reg - IDX_W'(1);
            last_next  = bidx_rd_reg;
        end
        if (cmd.link_new)
        begin
            depth_next = depth_reg + IDX_W'(1);
            count_next = new_idx;
            if (depth_reg == '0)
            begin
                root_next = new_idx;
            end
        end
        if (cmd.start_walk)
        begin
            cur_next = root_reg;
            sp_next  = '0;
        end
        if (cmd.step)
        begin
            if (l_nz)
            begin
                cur_next = l_rd_reg;
                if (r_nz)
                begin
                    sp_next = sp_reg + IDX_W'(1);
                end
            end
            else if (r_nz)
            begin
                cur_next = r_rd_reg;
            end
            else
            begin
                sp_next = sp_reg - IDX_W'(1);
            end
        end
        if (cmd.take_pop)
        begin
            cur_next = w_rd_reg;
        end

        if (oval_reg && !out_stall)
        begin
            oval_next = 1'b0;
        end
        if (cmd.emit || cmd.emit_empty)
        begin
            oval_next = 1'b1;
        end

        if (cmd.clear)
        begin
            depth_next = '0;
            count_next = '0;
            root_next  = '0;
            sp_next    = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            count_reg <= '0;
            root_reg  <= '0;
            sp_reg    <= '0;
            cur_reg   <= '0;
            last_reg  <= '0;
            ovf_reg   <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            depth_reg <= depth_next;
            count_reg <= count_next;
            root_reg  <= root_next;
            sp_reg    <= sp_next;
            cur_reg   <= cur_next;
            last_reg  <= last_next;
            ovf_reg   <= ovf_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
        begin
            nk_reg <= key[CMP_W-1:0];
        end
        if (cmd.rd_build)
        begin
            bidx_rd_reg <= bidx_mem[ADDR_W'(depth_reg - IDX_W'(1))];
            bkey_rd_reg <= bkey_mem[ADDR_W'(depth_reg - IDX_W'(1))];
        end
        if (cmd.link_new)
        begin
            bidx_mem[ADDR_W'(depth_reg)] <= new_idx;
            bkey_mem[ADDR_W'(depth_reg)] <= nk_reg;
            left_mem[node_addr(new_idx)] <= last_reg;
        end
        if (rwr_en)
        begin
            right_mem[rwr_addr] <= rwr_data;
        end
        if (cmd.rd_links)
        begin
            l_rd_reg <= left_mem[node_addr(cur_reg)];
            r_rd_reg <= right_mem[node_addr(cur_reg)];
        end
        if (cmd.step && l_nz && r_nz)
        begin
            wstk_mem[ADDR_W'(sp_reg)] <= r_rd_reg;
        end
        if (cmd.step && !l_nz && !r_nz)
        begin
            w_rd_reg <= wstk_mem[ADDR_W'(sp_reg - IDX_W'(1))];
        end
        if (cmd.emit)
        begin
            node_reg     <= OUT_IDX_W'(cur_reg);
            left_reg     <= OUT_IDX_W'(l_rd_reg);
            right_reg    <= OUT_IDX_W'(r_rd_reg);
            last_out_reg <= !l_nz && !r_nz && (sp_reg == '0);
            ovf_out_reg  <= ovf_reg;
            empty_reg    <= 1'b0;
        end
        else if (cmd.emit_empty)
        begin
            node_reg     <= '0;
            left_reg     <= '0;
            right_reg    <= '0;
            last_out_reg <= 1'b0;
            ovf_out_reg  <= 1'b0;
            empty_reg    <= 1'b1;
        end
    end

    assign out_valid   = oval_reg;
    assign node_index  = node_reg;
    assign left_child  = left_reg;
    assign right_child = right_reg;
    assign is_last     = last_out_reg;
    assign overflowed  = ovf_out_reg;
    assign empty_tree  = empty_reg;

endmodule

[rtl/min_cartesian_tree_builder.sv]
// ----------------------------------------------------------------------------
// min_cartesian_tree_builder
// Min-rooted Cartesian tree over pushed keys; finish emits nodes in preorder.
//
//   channel | signals                    | direction
//   --------+----------------------------+------------------------------
//   in      | in_valid in_stall          | action, key in
//   out     | out_valid out_stall        | node_index .. empty_tree out
//
// A push onto an empty stack links at once; otherwise it reads and compares
// the top entry, pops while its key is greater, and links. A push to a full
// store only sets the overflow flag. Finish walks in preorder, returning to
// deferred right subtrees from the walk stack. Reset clears counters and
// state only; memories need no clearing pass. The result register lets the
// next item in while a result waits; a stalled output pauses the walk.
// ----------------------------------------------------------------------------
module min_cartesian_tree_builder #(
    parameter int MAX_NODES = 64,
    parameter int KEY_BITS  = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              action,
    input  logic [mctb_pkg::KEY_W-1:0]        key,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [mctb_pkg::OUT_IDX_W-1:0]    node_index,
    output logic [mctb_pkg::OUT_IDX_W-1:0]    left_child,
    output logic [mctb_pkg::OUT_IDX_W-1:0]    right_child,
    output logic                              is_last,
    output logic                              overflowed,
    output logic                              empty_tree
);
    import mctb_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    mctb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    mctb_dp #(
        .MAX_NODES (MAX_NODES),
        .KEY_BITS  (KEY_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .key         (key),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .node_index  (node_index),
        .left_child  (left_child),
        .right_child (right_child),
        .is_last     (is_last),
        .overflowed  (overflowed),
        .empty_tree  (empty_tree)
    );

`ifndef SYNTH
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit || cmd.emit_empty) |-> status.out_free)
        else $error("result loaded over a waiting result");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> !status.depth_zero)
        else $error("build stack popped while empty");

    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && empty_tree) |-> (node_index == '0 && left_child == '0
            && right_child == '0 && !is_last && !overflowed))
        else $error("empty result carries nonzero fields");

    a_clear_after: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (status.count_zero && status.depth_zero))
        else $error("state not cleared after finish");
`endif

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for min_cartesian_tree_builder. Push and finish items
// go in from a queue with random gaps; an in-bench tree builder forms the
// expected preorder node list per finish, and every emitted node is checked
// field by field under random output stalls.
// ----------------------------------------------------------------------------
module testbench;

    import mctb_pkg::*;

    localparam int  MAX_NODES  = 64;
    localparam int  KEY_BITS   = 32;
    localparam int  IDLE_LIMIT = 3000;
    localparam int  ITEM_COUNT = 230;
    localparam int  DRAIN_CYCLES = 300;

    typedef struct {
        bit             act;
        bit [KEY_W-1:0] k;
        bit             hold;
    } tree_cmd_t;

    typedef struct {
        bit [OUT_IDX_W-1:0] node_index;
        bit [OUT_IDX_W-1:0] left_child;
        bit [OUT_IDX_W-1:0] right_child;
        bit                 is_last;
        bit                 overflowed;
        bit                 empty_tree;
    } node_result_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic                 action      = ACT_PUSH;
    logic [KEY_W-1:0]     key         = '0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    logic [OUT_IDX_W-1:0] node_index;
    logic [OUT_IDX_W-1:0] left_child;
    logic [OUT_IDX_W-1:0] right_child;
    logic                 is_last;
    logic                 overflowed;
    logic                 empty_tree;

    tree_cmd_t    pending_cmds[$];
    node_result_t expected_nodes[$];

    // in-bench tree state
    bit [KEY_W-1:0]     key_mem[1:MAX_NODES];
    bit [OUT_IDX_W-1:0] lft[1:MAX_NODES];
    bit [OUT_IDX_W-1:0] rgt[1:MAX_NODES];
    bit [OUT_IDX_W-1:0] build_stk[0:MAX_NODES-1];
    int                 build_depth;
    int                 node_count;
    int                 root_idx;
    bit                 ovf_seen;

    int errors;
    int items_in;
    int nodes_out;
    int finishes;
    int empty_finishes;
    int ovf_finishes;
    int idle_cycles;

    min_cartesian_tree_builder #(
        .MAX_NODES (MAX_NODES),
        .KEY_BITS  (KEY_BITS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .key         (key),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .node_index  (node_index),
        .left_child  (left_child),
        .right_child (right_child),
        .is_last     (is_last),
        .overflowed  (overflowed),
        .empty_tree  (empty_tree)
    );

    always #6 clk = ~clk;

    function automatic void tree_clear();
        build_depth = 0;
        node_count  = 0;
        root_idx    = 0;
        ovf_seen    = 1'b0;
    endfunction

    function automatic void tree_push(bit [KEY_W-1:0] k);
        int idx;
        int last;
        if (node_count >= MAX_NODES)
        begin
            ovf_seen = 1'b1;
            return;
        end
        idx = node_count + 1;
        last = 0;
        key_mem[idx] = k;
        while (build_depth > 0 && key_mem[build_stk[build_depth-1]] > k)
        begin
            last = int'(build_stk[build_depth-1]);
            build_depth--;
        end
        if (build_depth > 0)
            rgt[build_stk[build_depth-1]] = OUT_IDX_W'(idx);
        else
            root_idx = idx;
        lft[idx] = OUT_IDX_W'(last);
        rgt[idx] = '0;
        build_stk[build_depth] = OUT_IDX_W'(idx);
        build_depth++;
        node_count = idx;
    endfunction

    function automatic void tree_emit_preorder();
        node_result_t       r;
        bit [OUT_IDX_W-1:0] walk[$];
        int                 u;
        finishes++;
        if (node_count == 0)
        begin
            r = '{default: 0};
            r.empty_tree = 1'b1;
            expected_nodes.insert(expected_nodes.size(), r);
            empty_finishes++;
        end
        else
        begin
            if (ovf_seen)
                ovf_finishes++;
            walk.push_front(OUT_IDX_W'(root_idx));
            while (walk.size() > 0)
            begin
                u = int'(walk.pop_front());
                r.node_index  = OUT_IDX_W'(u);
                r.left_child  = lft[u];
                r.right_child = rgt[u];
                r.overflowed  = ovf_seen;
                r.empty_tree  = 1'b0;
                if (rgt[u] != 0)
                    walk.push_front(rgt[u]);
                if (lft[u] != 0)
                    walk.push_front(lft[u]);
                r.is_last = (walk.size() == 0);
                expected_nodes.insert(expected_nodes.size(), r);
            end
        end
        tree_clear();
    endfunction

    function automatic int pick_gap(inout int burst);
        int roll;
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4)
        begin
            burst = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic bit [KEY_W-1:0] pick_key(int mode);
        case (mode)
            1: return $urandom_range(0, 7);
            2:
            begin
                case ($urandom_range(0, 4))
                    0: return '0;
                    1: return '1;
                    2: return 32'h8000_0000;
                    3: return 32'h7fff_ffff;
                    default: return $urandom;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic add_cmd(bit act, bit [KEY_W-1:0] k, bit hold);
        tree_cmd_t c;
        c.act  = act;
        c.k    = k;
        c.hold = hold;
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    task automatic check_node();
        node_result_t e;
        nodes_out++;
        if (expected_nodes.size() == 0)
        begin
            $display("%0t: unexpected node %0d (left %0d right %0d last %0d ovf %0d empty %0d)",
                     $time, node_index, left_child, right_child, is_last, overflowed,
                     empty_tree);
            errors++;
            return;
        end
        e = expected_nodes.pop_front();
        if (node_index !== e.node_index)
        begin
            $display("%0t: node_index expected %0d got %0d", $time, e.node_index, node_index);
            errors++;
        end
        if (left_child !== e.left_child)
        begin
            $display("%0t: left_child expected %0d got %0d", $time, e.left_child, left_child);
            errors++;
        end
        if (right_child !== e.right_child)
        begin
            $display("%0t: right_child expected %0d got %0d", $time, e.right_child,
                     right_child);
            errors++;
        end
        if (is_last !== e.is_last)
        begin
            $display("%0t: is_last expected %0d got %0d", $time, e.is_last, is_last);
            errors++;
        end
        if (overflowed !== e.overflowed)
        begin
            $display("%0t: overflowed expected %0d got %0d", $time, e.overflowed, overflowed);
            errors++;
        end
        if (empty_tree !== e.empty_tree)
        begin
            $display("%0t: empty_tree expected %0d got %0d", $time, e.empty_tree, empty_tree);
            errors++;
        end
    endtask

    // item driver
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        int        in_gap;
        int        in_burst;
        logic      go;
        tree_cmd_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap = 0;
            in_burst = 0;
        end
        else
        begin
            go = in_valid;
            if (in_valid && !in_stall)
            begin
                items_in++;
                if (action == ACT_FINISH)
                    tree_emit_preorder();
                else
                    tree_push(key);
                go = 1'b0;
                in_gap = pick_gap(in_burst);
            end
            if (!go)
            begin
                if (in_gap > 0)
                    in_gap--;
                else if (pending_cmds.size() > 0 &&
                         (!pending_cmds[0].hold || expected_nodes.size() == 0))
                begin
                    nxt = pending_cmds.pop_front();
                    action <= nxt.act;
                    key    <= nxt.k;
                    go = 1'b1;
                end
            end
            in_valid <= go;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin : watch_nodes
        int out_gap;
        int out_burst;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap = 0;
            out_burst = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                check_node();
                out_gap = pick_gap(out_burst);
            end
            else if (out_gap == 0 && out_burst == 0 && $urandom_range(0, 9) == 0)
                out_gap = $urandom_range(1, 12);
            if (out_gap > 0)
            begin
                out_gap--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        int  len;
        int  mode;
        bit  ovf_done;
        bit  hold_next;
        errors = 0;
        items_in = 0;
        nodes_out = 0;
        finishes = 0;
        empty_finishes = 0;
        ovf_finishes = 0;
        idle_cycles = 0;
        tree_clear();

        // directed: empty finish, single node, equal keys and extremes, sorted runs
        add_cmd(ACT_FINISH, '1, 1'b0);
        add_cmd(ACT_PUSH, '0, 1'b0);
        add_cmd(ACT_FINISH, $urandom, 1'b0);
        add_cmd(ACT_PUSH, '1, 1'b0);
        add_cmd(ACT_PUSH, '1, 1'b0);
        add_cmd(ACT_PUSH, 32'd5, 1'b0);
        add_cmd(ACT_PUSH, 32'd5, 1'b0);
        add_cmd(ACT_PUSH, '0, 1'b0);
        add_cmd(ACT_PUSH, '1, 1'b0);
        add_cmd(ACT_FINISH, '0, 1'b0);
        add_cmd(ACT_PUSH, 32'd1, 1'b1);
        add_cmd(ACT_PUSH, 32'd2, 1'b0);
        add_cmd(ACT_PUSH, 32'd3, 1'b0);
        add_cmd(ACT_FINISH, '1, 1'b0);
        add_cmd(ACT_PUSH, 32'd3, 1'b0);
        add_cmd(ACT_PUSH, 32'd2, 1'b0);
        add_cmd(ACT_PUSH, 32'd1, 1'b0);
        add_cmd(ACT_FINISH, '0, 1'b0);
        add_cmd(ACT_FINISH, $urandom, 1'b0);

        // random trees; one run past capacity
        ovf_done = 1'b0;
        hold_next = 1'b0;
        while (pending_cmds.size() < ITEM_COUNT)
        begin
            if (!ovf_done && pending_cmds.size() > 90)
            begin
                len = MAX_NODES + $urandom_range(1, 6);
                ovf_done = 1'b1;
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0:        len = 0;
                    1, 2, 3:  len = $urandom_range(11, 40);
                    default:  len = $urandom_range(1, 10);
                endcase
            end
            mode = $urandom_range(0, 2);
            for (int i = 0; i < len; i++)
            begin
                add_cmd(ACT_PUSH, pick_key(mode), hold_next);
                hold_next = 1'b0;
            end
            add_cmd(ACT_FINISH, $urandom, hold_next);
            hold_next = (len > MAX_NODES) || ($urandom_range(0, 9) == 0);
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_cmds.size() > 0 || in_valid || expected_nodes.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_nodes.size() > 0)
        begin
            $display("%0t: %0d expected nodes never emitted", $time, expected_nodes.size());
            errors++;
        end
        $display("ran %0d items: %0d finishes (%0d empty, %0d past capacity), %0d nodes checked",
                 items_in, finishes, empty_finishes, ovf_finishes, nodes_out);
        $display("%0d mismatches", errors);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
rtl/mctb_pkg.sv
rtl/mctb_ctrl.sv
rtl/mctb_dp.sv
rtl/min_cartesian_tree_builder.sv
tb/sv/testbench.sv
